// ===== design/beacon_tone_debouncer_assert.svh =====
// Assertion macros for the beacon tone debouncer checker.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef BEACON_TONE_DEBOUNCER_ASSERT_SVH
`define BEACON_TONE_DEBOUNCER_ASSERT_SVH

// same-cycle implication
`define BTD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("btd assertion failed");

// next-cycle implication
`define BTD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("btd assertion failed");

`endif

// ===== design/btd_pkg.sv =====
// Shared types and constants for the beacon tone debouncer.
// No dependencies; imported by every module of the block.
`default_nettype none

package btd_pkg;

   localparam int LEVEL_W    = 16;
   localparam int SUM_W      = 17;
   localparam int STAMP_W    = 32;
   localparam int WINDOW_W   = 16;
   localparam int RELOAD_W   = 8;
   localparam int CSR_DATA_W = 17;

   typedef logic [1:0] class_type;
   localparam class_type CLASS_UNKNOWN = 2'd0;
   localparam class_type CLASS_LOW     = 2'd1;
   localparam class_type CLASS_HIGH    = 2'd2;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type REG_PRESENCE_THRESHOLD = 2'd0;
   localparam csr_index_type REG_GATE_WINDOW_MS     = 2'd1;
   localparam csr_index_type REG_DEBOUNCE_RELOAD    = 2'd2;

   localparam logic [SUM_W-1:0]    THRESHOLD_RESET = 17'd100;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 16'd3500;
   localparam logic [RELOAD_W-1:0] RELOAD_RESET    = 8'd10;

   typedef struct packed {
      logic [SUM_W-1:0]    presence_threshold;
      logic [WINDOW_W-1:0] gate_window_ms;
      logic [RELOAD_W-1:0] debounce_reload;
   } cfg_type;

   typedef struct packed {
      logic                mode;
      logic [LEVEL_W-1:0]  low_tone_level;
      logic [LEVEL_W-1:0]  high_tone_level;
   } item_type;

   typedef struct packed {
      class_type           raw_class;
      class_type           stable_class;
      logic                gate_open;
      logic [STAMP_W-1:0]  open_stamp;
      logic                safe_to_go;
      logic                next_side_left;
   } result_type;

endpackage

`default_nettype wire

// ===== design/btd_csr.sv =====
// Configuration registers of the beacon tone debouncer.
// Depends on btd_pkg; writes to unknown indexes are dropped.
`default_nettype none

module btd_csr
   import btd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire csr_index_type         wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_PRESENCE_THRESHOLD: cfg_in.presence_threshold = wr_data[SUM_W-1:0];
            REG_GATE_WINDOW_MS:     cfg_in.gate_window_ms     = wr_data[WINDOW_W-1:0];
            REG_DEBOUNCE_RELOAD:    cfg_in.debounce_reload    = wr_data[RELOAD_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.presence_threshold <= THRESHOLD_RESET;
         cfg_ff.gate_window_ms     <= WINDOW_RESET;
         cfg_ff.debounce_reload    <= RELOAD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/btd_core.sv =====
// Tone classification, debounce and gate timing state of the debouncer.
// Depends on btd_pkg; updates once per request and returns the post-update view.
`default_nettype none

module btd_core
   import btd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type    result
);

   logic                side_ff,       side_in;
   logic [LEVEL_W-1:0]  left_low_ff,   left_low_in;
   logic [LEVEL_W-1:0]  left_high_ff,  left_high_in;
   logic [LEVEL_W-1:0]  right_low_ff,  right_low_in;
   logic [LEVEL_W-1:0]  right_high_ff, right_high_in;
   class_type           last_raw_ff,   last_raw_in;
   logic [RELOAD_W-1:0] count_ff,      count_in;
   class_type           settled_ff,    settled_in;
   logic [STAMP_W-1:0]  opened_ff,     opened_in;
   logic [STAMP_W-1:0]  now_ff,        now_in;
   // now_ms minus opened_at, kept alongside so no subtract is needed
   logic [STAMP_W-1:0]  elapsed_ff,    elapsed_in;

   logic                meas;
   logic [SUM_W-1:0]    low_sum;
   logic [SUM_W-1:0]    high_sum;
   class_type           raw;

   assign meas          = !item.mode;
   assign left_low_in   = (meas && side_ff)  ? item.low_tone_level  : left_low_ff;
   assign left_high_in  = (meas && side_ff)  ? item.high_tone_level : left_high_ff;
   assign right_low_in  = (meas && !side_ff) ? item.low_tone_level  : right_low_ff;
   assign right_high_in = (meas && !side_ff) ? item.high_tone_level : right_high_ff;

   assign low_sum  = {1'b0, left_low_in}  + {1'b0, right_low_in};
   assign high_sum = {1'b0, left_high_in} + {1'b0, right_high_in};

   always_comb begin
      if (high_sum > low_sum && high_sum >= cfg.presence_threshold) begin
         raw = CLASS_HIGH;
      end else if (low_sum > high_sum && low_sum >= cfg.presence_threshold) begin
         raw = CLASS_LOW;
      end else begin
         raw = CLASS_UNKNOWN;
      end
   end

   always_comb begin
      side_in     = side_ff;
      last_raw_in = last_raw_ff;
      count_in    = count_ff;
      settled_in  = settled_ff;
      opened_in   = opened_ff;
      now_in      = now_ff;
      elapsed_in  = elapsed_ff;
      if (item.mode) begin
         now_in     = now_ff + STAMP_W'(1);
         elapsed_in = elapsed_ff + STAMP_W'(1);
      end else begin
         side_in     = !side_ff;
         last_raw_in = raw;
         if (raw != last_raw_ff) begin
            count_in = cfg.debounce_reload;
         end else if (count_ff != '0) begin
            count_in = count_ff - RELOAD_W'(1);
         end
         if (count_in == '0) begin
            if (raw == CLASS_LOW && settled_ff == CLASS_HIGH) begin
               opened_in  = now_ff;
               elapsed_in = '0;
            end
            settled_in = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff       <= 1'b1;
         left_low_ff   <= '0;
         left_high_ff  <= '0;
         right_low_ff  <= '0;
         right_high_ff <= '0;
         last_raw_ff   <= CLASS_UNKNOWN;
         count_ff      <= '0;
         settled_ff    <= CLASS_UNKNOWN;
         opened_ff     <= '0;
         now_ff        <= '0;
         elapsed_ff    <= '0;
      end else if (advance) begin
         side_ff       <= side_in;
         left_low_ff   <= left_low_in;
         left_high_ff  <= left_high_in;
         right_low_ff  <= right_low_in;
         right_high_ff <= right_high_in;
         last_raw_ff   <= last_raw_in;
         count_ff      <= count_in;
         settled_ff    <= settled_in;
         opened_ff     <= opened_in;
         now_ff        <= now_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   assign result.raw_class      = last_raw_in;
   assign result.stable_class   = settled_in;
   assign result.gate_open      = (settled_in == CLASS_LOW);
   assign result.open_stamp     = opened_in;
   assign result.safe_to_go     = (elapsed_in < {{(STAMP_W-WINDOW_W){1'b0}}, cfg.gate_window_ms});
   assign result.next_side_left = side_in;

endmodule

`default_nettype wire

// ===== design/beacon_tone_debouncer.sv =====
// Beacon tone debouncer top level: input register, core update, response register.
// An accepted request goes from the input register through btd_core to rsp_ff.
// Throughput: one request per cycle unless rsp_ready stalls; one btd_core pass each.
// Reset clears the core state, restores register defaults, and empties both stages.
// Depends on btd_pkg, btd_csr and btd_core.
`default_nettype none

module beacon_tone_debouncer
   import btd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire logic [LEVEL_W-1:0]    req_low_tone_level,
   input  wire logic [LEVEL_W-1:0]    req_high_tone_level,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output class_type                  rsp_raw_class,
   output class_type                  rsp_stable_class,
   output logic                       rsp_gate_open,
   output logic [STAMP_W-1:0]         rsp_open_stamp,
   output logic                       rsp_safe_to_go,
   output logic                       rsp_next_side_left,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire csr_index_type         csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type core_result;
   cfg_type    cfg;
   logic       advance;
   logic       req_fire;

   assign csr_ready = 1'b1;

   btd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.mode            <= req_mode;
         s1_item_ff.low_tone_level  <= req_low_tone_level;
         s1_item_ff.high_tone_level <= req_high_tone_level;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   btd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_raw_class      = rsp_ff.raw_class;
   assign rsp_stable_class   = rsp_ff.stable_class;
   assign rsp_gate_open      = rsp_ff.gate_open;
   assign rsp_open_stamp     = rsp_ff.open_stamp;
   assign rsp_safe_to_go     = rsp_ff.safe_to_go;
   assign rsp_next_side_left = rsp_ff.next_side_left;

endmodule

`default_nettype wire

// ===== design/btd_checker.sv =====
// Port-level checker for the beacon tone debouncer, bound to the top level.
// Depends on btd_pkg and beacon_tone_debouncer_assert.svh.
`default_nettype none

`include "beacon_tone_debouncer_assert.svh"

module btd_checker
   import btd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  req_mode,
   input wire logic [LEVEL_W-1:0]    req_low_tone_level,
   input wire logic [LEVEL_W-1:0]    req_high_tone_level,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire class_type             rsp_raw_class,
   input wire class_type             rsp_stable_class,
   input wire logic                  rsp_gate_open,
   input wire logic [STAMP_W-1:0]    rsp_open_stamp,
   input wire logic                  rsp_safe_to_go,
   input wire logic                  rsp_next_side_left
);

   `BTD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   `BTD_ASSERT_NOW(a_gate_follows_class, clock, reset, rsp_valid,
                   rsp_gate_open == (rsp_stable_class == CLASS_LOW))

   // every new response comes from a request taken earlier through the input register
   `BTD_ASSERT_NOW(a_rsp_from_request, clock, reset, $rose(rsp_valid),
                   $past(req_valid && req_ready, 2))

   `BTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_open_stamp) && $stable(rsp_stable_class) && $stable(rsp_raw_class) && $stable(rsp_gate_open) && $stable(rsp_safe_to_go) && $stable(rsp_next_side_left))

   `BTD_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready,
                    req_valid && $stable(req_mode) && $stable(req_low_tone_level) && $stable(req_high_tone_level))

endmodule

bind beacon_tone_debouncer btd_checker u_btd_checker (.*);

`default_nettype wire
